// File: rtl/tfr_pkg.sv
package tfr_pkg;

  // Converter frame layout
  localparam logic [31:0] FAULT_CMP_MASK = 32'h0001_0007;
  localparam int unsigned FAULT_FLAG_BIT = 16;
  localparam int unsigned QUARTER_LSB    = 18;
  localparam int unsigned QUARTER_W      = 14;
  localparam int unsigned FAULT_W        = 3;

  // Fixed-point widths
  localparam int unsigned TEMP_W    = 20;          // 1/256 degC
  localparam int unsigned DELTA_W   = TEMP_W + 1;
  localparam int unsigned WEIGHT_W  = 17;          // Q0.16 plus the "one" code
  localparam int unsigned FPROD_W   = DELTA_W + WEIGHT_W + 1;
  localparam int unsigned INTV_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned RPROD_W   = DELTA_W + 17;
  localparam int unsigned DVD_W     = RPROD_W - 1;  // magnitude of the rate product
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  localparam logic [WEIGHT_W-1:0] ONE_Q16       = 17'h1_0000;
  localparam logic signed [16:0]  MS_PER_MINUTE = 17'sd60000;
  localparam int unsigned         Q_FRAC_SHIFT  = 16;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    ACT_SAMPLE     = 2'd0,
    ACT_CLR_FILTER = 2'd1,
    ACT_CLR_RATE   = 2'd2,
    ACT_NOP        = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_FILTER_WEIGHT = 2'd0,
    CFG_RATE_INTERVAL = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_SAMPLE,
    CMD_FAULT,
    CMD_CLR_FILTER,
    CMD_CLR_RATE,
    CMD_NOP
  } cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FMUL,
    BK_FADD,
    BK_RATE,
    BK_RMUL,
    BK_DSTART,
    BK_DIV,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] frame_first;
    logic [31:0] frame_second;
    logic [31:0] frame_third;
    logic [31:0] time_ms;
  } req_t;

  typedef struct packed {
    logic signed [QUARTER_W-1:0] sample_quarter;
    logic signed [TEMP_W-1:0]    smoothed_temp;
    logic signed [RATE_W-1:0]    rise_rate;
    logic [FAULT_W-1:0]          fault_code;
    logic                        fault_now;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } cfg_t;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    cmd_e                        kind;
    logic signed [QUARTER_W-1:0] quarter;
    logic [FAULT_W-1:0]          fault_bits;
    logic [TIME_W-1:0]           time_ms;
  } cmd_t;

endpackage

// File: rtl/tfr_if.sv
interface tfr_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tfr_front.sv
module tfr_front
  import tfr_pkg::*;
(
  tfr_if.sink         req_i,
  output logic        push_o,
  input  logic        push_ready_i,
  output cmd_t        cmd_o
);

  logic [31:0] frame;

  assign push_o      = req_i.valid;
  assign req_i.ready = push_ready_i;

  always_comb begin
    // disagreeing fault bits on the first two reads: trust the third
    frame = req_i.data.frame_first;
    if ((req_i.data.frame_first & FAULT_CMP_MASK) !=
        (req_i.data.frame_second & FAULT_CMP_MASK)) begin
      frame = req_i.data.frame_third;
    end

    cmd_o.kind       = CMD_NOP;
    cmd_o.quarter    = '0;
    cmd_o.fault_bits = '0;
    cmd_o.time_ms    = req_i.data.time_ms;

    case (req_i.data.action)
      ACT_SAMPLE: begin
        if (frame[FAULT_FLAG_BIT]) begin
          cmd_o.kind       = CMD_FAULT;
          cmd_o.fault_bits = frame[FAULT_W-1:0];
        end else begin
          cmd_o.kind    = CMD_SAMPLE;
          cmd_o.quarter = frame[QUARTER_LSB +: QUARTER_W];
        end
      end
      ACT_CLR_FILTER: cmd_o.kind = CMD_CLR_FILTER;
      ACT_CLR_RATE:   cmd_o.kind = CMD_CLR_RATE;
      default:        cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// File: rtl/tfr_fifo.sv
module tfr_fifo
  import tfr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic push_ready_o,
  input  cmd_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d;
  logic [FIFO_AW-1:0] rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign valid_o      = (cnt_q != '0);
  assign data_o       = mem_q[rd_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: rtl/tfr_div.sv
module tfr_div
  import tfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [TIME_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DVD_W-1:0]  quotient_o
);

  // Restoring divider, one quotient bit per cycle; dvd_q turns into the quotient.
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [TIME_W-1:0]    rem_q, rem_d;
  logic [TIME_W-1:0]    dsr_q, dsr_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [TIME_W:0]      rem_sh;
  logic [TIME_W+1:0]    trial;

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dsr_q};

    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[TIME_W+1]) begin
        rem_d = trial[TIME_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[TIME_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

endmodule

// File: rtl/tfr_back.sv
module tfr_back
  import tfr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tfr_if.sink  cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  tfr_if.source rsp_o
);

  back_state_e state_q, state_d;

  // configuration
  logic [WEIGHT_W-1:0] weight_q, weight_d;
  logic [INTV_W-1:0]   interval_q, interval_d;

  // filter and rate state
  logic signed [TEMP_W-1:0]    filt_q, filt_d;
  logic                        filt_primed_q, filt_primed_d;
  logic signed [TEMP_W-1:0]    base_temp_q, base_temp_d;
  logic [TIME_W-1:0]           base_time_q, base_time_d;
  logic                        rate_primed_q, rate_primed_d;
  logic signed [RATE_W-1:0]    held_q, held_d;
  logic [FAULT_W-1:0]          fault_q, fault_d;

  // per-request working registers
  logic [TIME_W-1:0]           now_q, now_d;
  logic signed [QUARTER_W-1:0] quarter_q, quarter_d;
  logic                        fnow_q, fnow_d;
  logic signed [FPROD_W-1:0]   fprod_q, fprod_d;
  logic signed [DELTA_W-1:0]   delta_q, delta_d;
  logic [TIME_W-1:0]           elapsed_q, elapsed_d;
  logic signed [RPROD_W-1:0]   rprod_q, rprod_d;
  logic                        neg_q, neg_d;

  // output register
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  logic [WEIGHT_W-1:0]       w_eff;
  logic signed [WEIGHT_W:0]  w_signed;
  logic signed [TEMP_W-1:0]  x_cur;
  logic signed [DELTA_W-1:0] fdiff;
  logic [TIME_W-1:0]         elapsed;
  logic [INTV_W-1:0]         interval_eff;
  logic [RPROD_W-1:0]        rprod_abs;
  logic                      div_start;
  logic                      div_done;
  logic [DVD_W-1:0]          div_quo;
  logic signed [RATE_W-1:0]  rate_sat;

  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  tfr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rprod_abs[DVD_W-1:0]),
    .divisor_i  (elapsed_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    w_eff        = (weight_q > ONE_Q16) ? ONE_Q16 : weight_q;
    w_signed     = {1'b0, w_eff};
    x_cur        = {quarter_q, 6'b000000};  // quarter degree to 1/256 degree
    fdiff        = {x_cur[TEMP_W-1], x_cur} - {filt_q[TEMP_W-1], filt_q};
    elapsed      = now_q - base_time_q;
    interval_eff = (interval_q == '0) ? INTV_W'(1) : interval_q;
    rprod_abs    = rprod_q[RPROD_W-1] ? -rprod_q : rprod_q;

    // truncated quotient magnitude, signed and clipped to 32 bits
    if (neg_q) begin
      if (div_quo[DVD_W-1:RATE_W] != '0 ||
          (div_quo[RATE_W-1] && div_quo[RATE_W-2:0] != '0)) begin
        rate_sat = {1'b1, {(RATE_W-1){1'b0}}};
      end else begin
        rate_sat = -$signed(div_quo[RATE_W-1:0]);
      end
    end else begin
      if (div_quo[DVD_W-1:RATE_W-1] != '0) begin
        rate_sat = {1'b0, {(RATE_W-1){1'b1}}};
      end else begin
        rate_sat = $signed(div_quo[RATE_W-1:0]);
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    weight_d      = weight_q;
    interval_d    = interval_q;
    filt_d        = filt_q;
    filt_primed_d = filt_primed_q;
    base_temp_d   = base_temp_q;
    base_time_d   = base_time_q;
    rate_primed_d = rate_primed_q;
    held_d        = held_q;
    fault_d       = fault_q;
    now_d         = now_q;
    quarter_d     = quarter_q;
    fnow_d        = fnow_q;
    fprod_d       = fprod_q;
    delta_d       = delta_q;
    elapsed_d     = elapsed_q;
    rprod_d       = rprod_q;
    neg_d         = neg_q;
    rsp_valid_d   = rsp_valid_q & ~rsp_o.ready;
    rsp_d         = rsp_q;
    cmd_pop_o     = 1'b0;
    div_start     = 1'b0;

    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_FILTER_WEIGHT: weight_d   = cfg_i.data.value[WEIGHT_W-1:0];
        CFG_RATE_INTERVAL: interval_d = cfg_i.data.value[INTV_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          now_d     = cmd_i.time_ms;
          quarter_d = '0;
          fnow_d    = 1'b0;
          case (cmd_i.kind)
            CMD_SAMPLE: begin
              fault_d   = '0;
              quarter_d = cmd_i.quarter;
              if (!filt_primed_q) begin
                filt_d        = {cmd_i.quarter, 6'b000000};
                filt_primed_d = 1'b1;
                state_d       = BK_RATE;
              end else begin
                state_d = BK_FMUL;
              end
            end
            CMD_FAULT: begin
              fault_d = cmd_i.fault_bits;
              fnow_d  = 1'b1;
              state_d = BK_RATE;
            end
            CMD_CLR_FILTER: begin
              filt_d        = '0;
              filt_primed_d = 1'b0;
              state_d       = BK_OUT;
            end
            CMD_CLR_RATE: begin
              base_temp_d   = '0;
              base_time_d   = '0;
              rate_primed_d = 1'b0;
              held_d        = '0;
              state_d       = BK_OUT;
            end
            default: state_d = BK_OUT;
          endcase
        end
      end
      BK_FMUL: begin
        // f + w*(x - f)/2^16 equals the weighted sum, floor included
        fprod_d = fdiff * w_signed;
        state_d = BK_FADD;
      end
      BK_FADD: begin
        filt_d  = filt_q + fprod_q[Q_FRAC_SHIFT +: TEMP_W];
        state_d = BK_RATE;
      end
      BK_RATE: begin
        if (!rate_primed_q) begin
          base_temp_d   = filt_q;
          base_time_d   = now_q;
          rate_primed_d = 1'b1;
          state_d       = BK_OUT;
        end else if (elapsed >= TIME_W'(interval_eff)) begin
          delta_d   = {filt_q[TEMP_W-1], filt_q} - {base_temp_q[TEMP_W-1], base_temp_q};
          elapsed_d = elapsed;
          state_d   = BK_RMUL;
        end else begin
          state_d = BK_OUT;
        end
      end
      BK_RMUL: begin
        rprod_d = delta_q * MS_PER_MINUTE;
        state_d = BK_DSTART;
      end
      BK_DSTART: begin
        neg_d     = rprod_q[RPROD_W-1];
        div_start = 1'b1;
        state_d   = BK_DIV;
      end
      BK_DIV: begin
        if (div_done) begin
          held_d      = rate_sat;
          base_temp_d = filt_q;
          base_time_d = now_q;
          state_d     = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d          = 1'b1;
          rsp_d.sample_quarter = quarter_q;
          rsp_d.smoothed_temp  = filt_q;
          rsp_d.rise_rate      = held_q;
          rsp_d.fault_code     = fault_q;
          rsp_d.fault_now      = fnow_q;
          state_d              = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q      <= WEIGHT_W'(6554);
      interval_q    <= INTV_W'(1000);
      filt_q        <= '0;
      filt_primed_q <= 1'b0;
      base_temp_q   <= '0;
      base_time_q   <= '0;
      rate_primed_q <= 1'b0;
      held_q        <= '0;
      fault_q       <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      weight_q      <= weight_d;
      interval_q    <= interval_d;
      filt_q        <= filt_d;
      filt_primed_q <= filt_primed_d;
      base_temp_q   <= base_temp_d;
      base_time_q   <= base_time_d;
      rate_primed_q <= rate_primed_d;
      held_q        <= held_d;
      fault_q       <= fault_d;
      rsp_valid_q   <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    quarter_q <= quarter_d;
    fnow_q    <= fnow_d;
    fprod_q   <= fprod_d;
    delta_q   <= delta_d;
    elapsed_q <= elapsed_d;
    rprod_q   <= rprod_d;
    neg_q     <= neg_d;
    rsp_q     <= rsp_d;
  end

endmodule

// File: rtl/thermocouple_filter_rate_of_rise.sv
// Thermocouple front end: picks one of three converter frames per request, latches
// fault codes, smooths the reading with an exponential filter and estimates the rate
// of rise in 1/256 degC per minute. A request that takes a sample and refreshes the
// rate goes through the 37-step restoring divider that forms delta*60000/elapsed;
// other requests skip the divider. A two-entry queue sits between the decoder and
// the filter/rate engine, and results leave through an output register, so up to
// four requests can be taken while the result side is stalled. Configuration writes
// are always accepted and must only be issued while no request is outstanding.
module thermocouple_filter_rate_of_rise
  import tfr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  tfr_if.sink   cfg_i,
  tfr_if.sink   req_i,
  tfr_if.source rsp_o
);

  logic push;
  logic push_ready;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  tfr_front u_front (
    .req_i        (req_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd)
  );

  tfr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .data_i       (push_cmd),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .data_o       (q_cmd)
  );

  tfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .rsp_o       (rsp_o)
  );

endmodule

// File: verif/thermocouple_filter_rate_of_rise_tb.sv
module thermocouple_filter_rate_of_rise_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned NUM_PHASES     = 7;
  localparam int unsigned RAND_PER_PHASE = 265;
  localparam longint      RATE_MAX       = 64'sd2147483647;
  localparam longint      RATE_MIN       = -RATE_MAX - 1;

  // Tracks filter, rate and fault state and holds the responses still due.
  class rise_rate_scoreboard;
    logic [16:0]        weight_q16;
    logic [15:0]        rate_interval;
    logic signed [20:0] filt_val;
    bit                 filt_seeded;
    logic signed [20:0] base_temp;
    logic [31:0]        base_ms;
    bit                 base_taken;
    logic signed [31:0] held_rate;
    logic [2:0]         held_fault;
    rsp_t               rsp_due_q[$];
    int                 errors;

    function new();
      weight_q16    = 17'd6554;
      rate_interval = 16'd1000;
      filt_val      = '0;
      filt_seeded   = 1'b0;
      base_temp     = '0;
      base_ms       = '0;
      base_taken    = 1'b0;
      held_rate     = '0;
      held_fault    = '0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        CFG_FILTER_WEIGHT: weight_q16 = val[16:0];
        CFG_RATE_INTERVAL: rate_interval = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return rsp_due_q.size();
    endfunction

    function rsp_t filter_and_rate(req_t r);
      rsp_t               o;
      logic [31:0]        frame;
      logic signed [13:0] qd;
      logic [31:0]        elapsed;
      longint             w;
      longint             s;
      longint             delta;
      longint             qv;
      longint             span;
      longint             lim;
      bit                 first_rate;
      o = '0;
      first_rate = 1'b0;
      if (r.action == ACT_CLR_FILTER) begin
        filt_seeded = 1'b0;
        filt_val    = '0;
      end else if (r.action == ACT_CLR_RATE) begin
        base_temp  = '0;
        base_ms    = '0;
        base_taken = 1'b0;
        held_rate  = '0;
      end else if (r.action == ACT_SAMPLE) begin
        frame = ((r.frame_first & FAULT_CMP_MASK) != (r.frame_second & FAULT_CMP_MASK)) ?
                r.frame_third : r.frame_first;
        if (frame[FAULT_FLAG_BIT]) begin
          held_fault  = frame[2:0];
          o.fault_now = 1'b1;
        end else begin
          held_fault       = '0;
          qd               = frame[31:18];
          o.sample_quarter = qd;
          if (!filt_seeded) begin
            filt_val    = 21'(longint'(qd) * 64);
            filt_seeded = 1'b1;
          end else begin
            w        = (weight_q16 > ONE_Q16) ? 64'sd65536 : longint'(weight_q16);
            s        = w * longint'(qd) * 64 + (64'sd65536 - w) * longint'(filt_val);
            filt_val = 21'(s >>> 16);
          end
        end
        if (!base_taken) begin
          base_temp  = filt_val;
          base_ms    = r.time_ms;
          base_taken = 1'b1;
          first_rate = 1'b1;
        end else begin
          elapsed = r.time_ms - base_ms;
          span    = longint'(elapsed);
          lim     = (rate_interval == 16'd0) ? 64'sd1 : longint'(rate_interval);
          if (span >= lim) begin
            delta = longint'(filt_val) - longint'(base_temp);
            qv    = (delta * 64'sd60000) / span;
            if (qv > RATE_MAX) held_rate = 32'sh7FFF_FFFF;
            else if (qv < RATE_MIN) held_rate = 32'sh8000_0000;
            else held_rate = 32'(qv);
            base_temp = filt_val;
            base_ms   = r.time_ms;
          end
        end
      end
      o.smoothed_temp = filt_val[19:0];
      o.rise_rate     = first_rate ? 32'sd0 : held_rate;
      o.fault_code    = held_fault;
      return o;
    endfunction

    function void note_request(req_t r);
      rsp_due_q.push_back(filter_and_rate(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp_rsp;
      if (rsp_due_q.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      exp_rsp = rsp_due_q.pop_front();
      if (got.sample_quarter !== exp_rsp.sample_quarter) begin
        $error("sample_quarter: expected %0d, actual %0d", exp_rsp.sample_quarter,
               got.sample_quarter);
        errors++;
      end
      if (got.smoothed_temp !== exp_rsp.smoothed_temp) begin
        $error("smoothed_temp: expected %0d, actual %0d", exp_rsp.smoothed_temp,
               got.smoothed_temp);
        errors++;
      end
      if (got.rise_rate !== exp_rsp.rise_rate) begin
        $error("rise_rate: expected %0d, actual %0d", exp_rsp.rise_rate, got.rise_rate);
        errors++;
      end
      if (got.fault_code !== exp_rsp.fault_code) begin
        $error("fault_code: expected %0d, actual %0d", exp_rsp.fault_code, got.fault_code);
        errors++;
      end
      if (got.fault_now !== exp_rsp.fault_now) begin
        $error("fault_now: expected %0d, actual %0d", exp_rsp.fault_now, got.fault_now);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tfr_if #(.T(cfg_t)) cfg_if ();
  tfr_if #(.T(req_t)) req_if ();
  tfr_if #(.T(rsp_t)) rsp_if ();

  thermocouple_filter_rate_of_rise u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  rise_rate_scoreboard sb;
  logic [31:0]         cur_ms;
  int                  cur_q;
  int unsigned         cycles = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
  end

  // Result side: switches at random between four stall styles.
  initial begin
    int          mode;
    int          left;
    logic [31:0] tick;
    rsp_if.ready = 1'b0;
    mode = 0;
    left = 0;
    tick = '0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(32, 400);
      end
      left--;
      tick++;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        2: rsp_if.ready <= ($urandom_range(0, 7) == 0);
        default: rsp_if.ready <= (tick[3:0] >= 4'd6);
      endcase
    end
  end

  function automatic logic [31:0] build_frame(int q, logic flt, int code);
    logic [31:0] f;
    f        = $urandom;
    f[31:18] = 14'(q);
    f[16]    = flt;
    f[2:0]   = 3'(code);
    return f;
  endfunction

  // Same fault-compare bits as f, everything else scrambled.
  function automatic logic [31:0] agree_with(logic [31:0] f);
    return ($urandom & ~FAULT_CMP_MASK) | (f & FAULT_CMP_MASK);
  endfunction

  function automatic req_t next_random_req();
    req_t        r;
    int unsigned pick;
    int unsigned span;
    logic [31:0] pat;
    r.frame_first  = $urandom;
    r.frame_second = $urandom;
    r.frame_third  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 4) r.action = ACT_CLR_FILTER;
    else if (pick < 8) r.action = ACT_CLR_RATE;
    else if (pick < 11) r.action = ACT_NOP;
    else r.action = ACT_SAMPLE;

    span = (sb.rate_interval == 16'd0) ? 1 : int'(sb.rate_interval);
    pick = $urandom_range(0, 99);
    if (pick < 75) cur_ms += $urandom_range(0, 2 * span);
    else if (pick < 88) cur_ms += $urandom_range(0, 3);
    else if (pick < 94) cur_ms = $urandom;
    else cur_ms = 32'hFFFF_FFFF - $urandom_range(0, span);
    r.time_ms = cur_ms;

    // mostly a slow drift, sometimes a jump or a rail
    pick = $urandom_range(0, 99);
    if (pick < 60) cur_q = cur_q + int'($urandom_range(0, 256)) - 128;
    else if (pick < 85) cur_q = int'($urandom_range(0, 16383)) - 8192;
    else cur_q = ($urandom_range(0, 1) != 0) ? 8191 : -8192;
    if (cur_q > 8191) cur_q = 8191;
    if (cur_q < -8192) cur_q = -8192;

    r.frame_first = build_frame(cur_q, ($urandom_range(0, 9) == 0), $urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      r.frame_second = agree_with(r.frame_first);
    end else if (pick < 92) begin
      pat = '0;
      while (pat == '0) pat = $urandom & FAULT_CMP_MASK;
      r.frame_second = agree_with(r.frame_first) ^ pat;
      r.frame_third  = build_frame(cur_q + int'($urandom_range(0, 64)) - 32,
                                   ($urandom_range(0, 4) == 0), $urandom_range(0, 7));
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input req_t r);
    req_if.data  <= r;
    req_if.valid <= 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [31:0] f1, input logic [31:0] f2,
                             input logic [31:0] f3, input logic [31:0] t);
    req_t r;
    r.action       = ACT_SAMPLE;
    r.frame_first  = f1;
    r.frame_second = f2;
    r.frame_third  = f3;
    r.time_ms      = t;
    send_req(r);
  endtask

  task automatic send_action(input action_e a);
    req_t r;
    r.action       = a;
    r.frame_first  = $urandom;
    r.frame_second = $urandom;
    r.frame_third  = $urandom;
    r.time_ms      = $urandom;
    send_req(r);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [16:0] w, input logic [15:0] iv);
    cfg_t c;
    c.index = CFG_FILTER_WEIGHT;
    c.value = 32'(w);
    cfg_if.data  <= c;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(CFG_FILTER_WEIGHT, c.value);
    @(negedge clk);
    c.index = CFG_RATE_INTERVAL;
    c.value = 32'(iv);
    cfg_if.data <= c;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(CFG_RATE_INTERVAL, c.value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] f;
    logic [16:0] ph_weight   [NUM_PHASES];
    logic [15:0] ph_interval [NUM_PHASES];
    int          sent;
    int          burst;
    int          gap;

    sb           = new();
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    cur_ms       = '0;
    cur_q        = 0;
    ph_weight    = '{17'd6554, 17'd0, 17'd65536, 17'd131071, 17'd1, 17'd65535, 17'd0};
    ph_interval  = '{16'd1000, 16'd1, 16'd0, 16'd65535, 16'd50, 16'd7, 16'd0};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: seeding, below/at interval, fault paths, clears, wrap
    f = build_frame(0, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'd0);
    f = build_frame(8191, 1'b0, 7);
    send_sample(f, agree_with(f), $urandom, 32'd400);
    f = build_frame(-8192, 1'b0, 2);
    send_sample(f, agree_with(f), $urandom, 32'd1000);
    f = build_frame(77, 1'b1, 7);
    send_sample(f, agree_with(f), $urandom, 32'd2100);
    f = build_frame(100, 1'b0, 0);
    send_sample(f, agree_with(f) ^ 32'h1, build_frame(5, 1'b1, 5), 32'd2200);
    f = build_frame(300, 1'b1, 3);
    send_sample(f, agree_with(f) ^ 32'h1_0000, build_frame(-1, 1'b0, 0), 32'd3300);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3400);
    send_sample(32'h0, 32'h0, 32'h0, 32'd3500);
    send_action(ACT_CLR_FILTER);
    f = build_frame(1234, 1'b0, 1);
    send_sample(f, agree_with(f), $urandom, 32'd4500);
    send_action(ACT_CLR_RATE);
    f = build_frame(-5, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'd4600);
    send_action(ACT_NOP);
    f = build_frame(50, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'hFFFF_FF00);
    f = build_frame(60, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'h0000_0400);
    send_sample(f, agree_with(f), $urandom, 32'h0000_0400);

    // weight of one, interval zero: full swings every ms saturate both ways
    wait_drained();
    set_config(17'd65536, 16'd0);
    f = build_frame(-8192, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'd10);
    f = build_frame(8191, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'd11);
    f = build_frame(-8192, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'd12);
    f = build_frame(8191, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'd12);

    // weight above one, longest interval
    wait_drained();
    set_config(17'd131071, 16'd65535);
    f = build_frame(100, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'd0);
    f = build_frame(200, 1'b0, 0);
    send_sample(f, agree_with(f), $urandom, 32'd65535);
    f = build_frame(9, 1'b1, 4);
    send_sample(f, agree_with(f), $urandom, 32'd200000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p >= 5) set_config(17'($urandom), 16'($urandom));
      else set_config(ph_weight[p], ph_interval[p]);
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        burst = $urandom_range(1, 24);
        while (burst != 0 && sent < RAND_PER_PHASE) begin
          send_req(next_random_req());
          sent++;
          burst--;
          // hold off mid-phase until the block has emptied out
          if (p == 2 && sent == RAND_PER_PHASE / 2) wait_drained();
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          req_if.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    wait_drained();
    repeat (60) @(negedge clk);
    if (sb.pending() != 0) begin
      $error("%0d responses never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tfr_pkg.sv
rtl/tfr_if.sv
rtl/tfr_front.sv
rtl/tfr_fifo.sv
rtl/tfr_div.sv
rtl/tfr_back.sv
rtl/thermocouple_filter_rate_of_rise.sv
verif/thermocouple_filter_rate_of_rise_tb.sv
